[design/rrld_pkg.sv]
package rrld_pkg;

   localparam int WORD_W     = 16;
   localparam int RUN_W      = 15;
   localparam int FIELD_W    = 5;
   localparam int GATE_W     = 16;
   localparam int NFIELDS_W  = 6;

   // Control word that marks the end of a field
   localparam logic [WORD_W-1:0] END_MARK = 16'h0001;

   // Result queue: room for the two results one word can cause, plus slack
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_ZERO_RUN  = 2'd1,
      KIND_FIELD_END = 2'd2,
      KIND_RAY_END   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [WORD_W-1:0]  value;
      logic [RUN_W-1:0]   run_length;
      logic [FIELD_W-1:0] field_index;
      logic [GATE_W-1:0]  gate_position;
      logic               overflow;
      logic               last;
   } rsp_item_type;

   // Decoder to queue: zero, one or two results from one word
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

[design/rrld_req_if.sv]
interface rrld_req_if;
   logic                        valid;
   logic                        ready;
   logic [rrld_pkg::WORD_W-1:0] word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

[design/rrld_rsp_if.sv]
interface rrld_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   kind;
   logic [rrld_pkg::WORD_W-1:0]  value;
   logic [rrld_pkg::RUN_W-1:0]   run_length;
   logic [rrld_pkg::FIELD_W-1:0] field_index;
   logic [rrld_pkg::GATE_W-1:0]  gate_position;
   logic                         overflow;
   logic                         last;

   modport source (output valid, output kind, output value, output run_length,
                   output field_index, output gate_position, output overflow,
                   output last, input ready);
   modport sink   (input valid, input kind, input value, input run_length,
                   input field_index, input gate_position, input overflow,
                   input last, output ready);
endinterface

[design/radar_ray_run_length_decoder.sv]
// Flow: an accepted word waits in the input register until the decoder takes it (only
//    while the queue has room for two results); the decoder writes its results into the queue.
// Throughput: one word per cycle while the queue holds two results or fewer. A field
//    end that closes the ray yields two results, drained one per cycle while ready is high.
// Reset (synchronous, active high): clears decoder state, empties the queue
//    and sets the fields-per-ray register to 1. No clearing pass is needed.
module radar_ray_run_length_decoder #(
   parameter int MAX_FIELDS = 32,
   parameter int MAX_GATES  = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   rrld_req_if.sink                       req_chan,
   rrld_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [rrld_pkg::NFIELDS_W-1:0] csr_write_data
);

   // Configuration register: fields per ray (clamped inside the decoder)
   logic [rrld_pkg::NFIELDS_W-1:0] fields_per_ray_ff;

   // Input register: holds one accepted word until the decoder takes it
   logic                          in_valid_ff, in_valid_in;
   logic [rrld_pkg::WORD_W-1:0]   in_word_ff;

   logic                          decode_fire;
   logic                          room_for_two;
   logic                          req_take;
   logic                          rsp_pop;
   rrld_pkg::push_type            push;
   rrld_pkg::rsp_item_type        head;
   logic [rrld_pkg::COUNT_W-1:0]  queue_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         fields_per_ray_ff <= rrld_pkg::NFIELDS_W'(1);
      end else if (csr_write_enable) begin
         fields_per_ray_ff <= csr_write_data;
      end
   end

   // Decode only when the queue can absorb the worst case of two results.
   // Counting on the registered fill level alone keeps the ready path short;
   // with a consumer that pops every cycle the input side stalls only while
   // the words produce results faster than one per cycle.
   assign room_for_two = queue_count <= rrld_pkg::COUNT_W'(rrld_pkg::QUEUE_DEPTH - 2);
   assign decode_fire  = in_valid_ff && room_for_two;

   // Accept a new transaction whenever the input register is empty or
   // is being drained into the decoder this cycle.
   assign req_chan.ready = (!in_valid_ff) || decode_fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (decode_fire) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload register: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_chan.word;
      end
   end

   rrld_decoder #(
      .MAX_FIELDS (MAX_FIELDS),
      .MAX_GATES  (MAX_GATES)
   ) u_decoder (
      .clock          (clock),
      .reset          (reset),
      .fire           (decode_fire),
      .word           (in_word_ff),
      .fields_per_ray (fields_per_ray_ff),
      .push           (push)
   );

   // Result queue doubles as the output register: the head entry drives
   // the result channel straight from storage.
   assign rsp_pop = rsp_chan.valid && rsp_chan.ready;

   rrld_out_queue u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (rsp_pop),
      .head  (head),
      .count (queue_count)
   );

   assign rsp_chan.valid         = queue_count != '0;
   assign rsp_chan.kind          = head.kind;
   assign rsp_chan.value         = head.value;
   assign rsp_chan.run_length    = head.run_length;
   assign rsp_chan.field_index   = head.field_index;
   assign rsp_chan.gate_position = head.gate_position;
   assign rsp_chan.overflow      = head.overflow;
   assign rsp_chan.last          = head.last;

   // The queue never fills past its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= rrld_pkg::COUNT_W'(rrld_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

   // Results are only produced from a held input word
   a_push_needs_word: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> in_valid_ff)
      else $error("decoder pushed results without an input word");

   // A decode step, which adds at most two entries, never fills the queue past its depth
   a_queue_growth: assert property (@(posedge clock) disable iff (reset)
      decode_fire |=> (queue_count <= rrld_pkg::COUNT_W'(rrld_pkg::QUEUE_DEPTH)))
      else $error("queue overflow after decode");

   // A ray end is always the final result of its word
   a_ray_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (head.kind == rrld_pkg::KIND_RAY_END)) |-> head.last)
      else $error("ray end result without last");

endmodule

[design/rrld_decoder.sv]
module rrld_decoder #(
   parameter int MAX_FIELDS = 32,
   parameter int MAX_GATES  = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic [rrld_pkg::WORD_W-1:0]    word,
   input  logic [rrld_pkg::NFIELDS_W-1:0] fields_per_ray,
   output rrld_pkg::push_type             push
);

   localparam int SUM_W = rrld_pkg::GATE_W + 1;

   logic                          lit_ff, lit_in;
   logic [rrld_pkg::RUN_W-1:0]    run_rem_ff, run_rem_in;
   logic [rrld_pkg::FIELD_W-1:0]  field_ff, field_in;
   logic [rrld_pkg::GATE_W-1:0]   gate_ff, gate_in;
   logic                          prev_end_ff, prev_end_in;
   logic                          ray_closed_ff, ray_closed_in;

   logic [rrld_pkg::RUN_W-1:0]     len;
   logic [SUM_W-1:0]               gate_sum;
   logic                           gate_ovf;
   logic [rrld_pkg::GATE_W-1:0]    gate_adv;
   logic [rrld_pkg::NFIELDS_W-1:0] nf_eff;
   logic                           closes_ray;
   rrld_pkg::rsp_item_type         blank;

   assign len = word[rrld_pkg::RUN_W-1:0];

   // Saturating gate advance: one gate for a data word, len for a zero run
   always_comb begin
      gate_sum = {1'b0, gate_ff} + (lit_ff ? SUM_W'(1) : SUM_W'(len));
      gate_ovf = gate_sum > SUM_W'(MAX_GATES);
      gate_adv = gate_ovf ? rrld_pkg::GATE_W'(MAX_GATES) : gate_sum[rrld_pkg::GATE_W-1:0];
   end

   // Clamp the field count to 1..MAX_FIELDS
   always_comb begin
      nf_eff = fields_per_ray;
      if (nf_eff == '0) begin
         nf_eff = rrld_pkg::NFIELDS_W'(1);
      end
      if (nf_eff > rrld_pkg::NFIELDS_W'(MAX_FIELDS)) begin
         nf_eff = rrld_pkg::NFIELDS_W'(MAX_FIELDS);
      end
      closes_ray = ({1'b0, field_ff} + rrld_pkg::NFIELDS_W'(1)) >= nf_eff;
   end

   always_comb begin
      blank = '{kind: rrld_pkg::KIND_DATA, value: '0, run_length: '0,
                field_index: field_ff, gate_position: '0, overflow: 1'b0,
                last: 1'b1};
      push.count    = 2'd0;
      push.item0    = blank;
      push.item1    = blank;
      lit_in        = lit_ff;
      run_rem_in    = run_rem_ff;
      field_in      = field_ff;
      gate_in       = gate_ff;
      prev_end_in   = prev_end_ff;
      ray_closed_in = ray_closed_ff;

      if (lit_ff) begin
         push.count               = 2'd1;
         push.item0.kind          = rrld_pkg::KIND_DATA;
         push.item0.value         = word;
         push.item0.gate_position = gate_ff;
         push.item0.overflow      = gate_ovf;
         gate_in                  = gate_adv;
         run_rem_in               = run_rem_ff - rrld_pkg::RUN_W'(1);
         if (run_rem_ff == rrld_pkg::RUN_W'(1)) begin
            lit_in = 1'b0;
         end
      end else if (word == rrld_pkg::END_MARK) begin
         if (ray_closed_ff) begin
            // swallow repeated end marks after the ray closed
            push.count = 2'd0;
         end else if (prev_end_ff) begin
            push.count             = 2'd1;
            push.item0.kind        = rrld_pkg::KIND_RAY_END;
            push.item0.field_index = field_ff - rrld_pkg::FIELD_W'(1);
         end else begin
            push.item0.kind          = rrld_pkg::KIND_FIELD_END;
            push.item0.gate_position = gate_ff;
            if (closes_ray) begin
               push.count       = 2'd2;
               push.item0.last  = 1'b0;
               push.item1.kind  = rrld_pkg::KIND_RAY_END;
            end else begin
               push.count  = 2'd1;
               field_in    = field_ff + rrld_pkg::FIELD_W'(1);
               gate_in     = '0;
               prev_end_in = 1'b1;
            end
         end
         if ((!ray_closed_ff) && (prev_end_ff || closes_ray)) begin
            lit_in        = 1'b0;
            run_rem_in    = '0;
            field_in      = '0;
            gate_in       = '0;
            prev_end_in   = 1'b0;
            ray_closed_in = 1'b1;
         end
      end else begin
         ray_closed_in = 1'b0;
         prev_end_in   = 1'b0;
         if (word[rrld_pkg::WORD_W-1]) begin
            if (len != '0) begin
               lit_in     = 1'b1;
               run_rem_in = len;
            end
         end else begin
            push.count               = 2'd1;
            push.item0.kind          = rrld_pkg::KIND_ZERO_RUN;
            push.item0.run_length    = len;
            push.item0.gate_position = gate_ff;
            push.item0.overflow      = gate_ovf;
            gate_in                  = gate_adv;
         end
      end

      if (!fire) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff        <= 1'b0;
         run_rem_ff    <= '0;
         field_ff      <= '0;
         gate_ff       <= '0;
         prev_end_ff   <= 1'b0;
         ray_closed_ff <= 1'b0;
      end else if (fire) begin
         lit_ff        <= lit_in;
         run_rem_ff    <= run_rem_in;
         field_ff      <= field_in;
         gate_ff       <= gate_in;
         prev_end_ff   <= prev_end_in;
         ray_closed_ff <= ray_closed_in;
      end
   end

endmodule

[design/rrld_out_queue.sv]
module rrld_out_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  rrld_pkg::push_type              push,
   input  logic                            pop,
   output rrld_pkg::rsp_item_type          head,
   output logic [rrld_pkg::COUNT_W-1:0]    count
);

   rrld_pkg::rsp_item_type mem [rrld_pkg::QUEUE_DEPTH];

   logic [rrld_pkg::PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rrld_pkg::PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rrld_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [rrld_pkg::PTR_W-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + rrld_pkg::PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rrld_pkg::PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + rrld_pkg::PTR_W'(pop);
      count_in  = count_ff + rrld_pkg::COUNT_W'(push.count)
                  - rrld_pkg::COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_next] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = mem[rd_ptr_ff];
   assign count = count_ff;

endmodule

[tb/radar_ray_run_length_decoder_test.sv]
`timescale 1ns / 1ps

module radar_ray_run_length_decoder_test;

   localparam int MAX_FIELDS    = 32;
   localparam int MAX_GATES     = 4096;
   localparam int MAX_WAIT      = 17;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS   = 60;
   localparam int CYCLE_LIMIT   = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_write_enable;
   logic [rrld_pkg::NFIELDS_W-1:0] csr_write_data;

   rrld_req_if req_if ();
   rrld_rsp_if rsp_if ();

   radar_ray_run_length_decoder #(
      .MAX_FIELDS (MAX_FIELDS),
      .MAX_GATES  (MAX_GATES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // Words waiting for the driver, and results predicted but not yet seen
   logic [rrld_pkg::WORD_W-1:0] pending_words [$];
   rrld_pkg::rsp_item_type      predicted_results [$];

   int  error_count   = 0;
   int  words_queued  = 0;
   int  cycle_count   = 0;
   logic req_handshake = 1'b0;
   logic rsp_handshake = 1'b0;
   logic rush          = 1'b0;   // when set, both sides run without idling
   int  gap_left      = 0;
   int  stall_left    = 0;

   // Decoder shadow state, mirrors the block after reset
   logic [rrld_pkg::NFIELDS_W-1:0] fields_cfg  = 6'd1;
   logic                           in_literal  = 1'b0;
   logic [rrld_pkg::RUN_W-1:0]     run_left    = '0;
   logic [rrld_pkg::FIELD_W-1:0]   field_cur   = '0;
   int                             gate_cnt    = 0;
   logic                           prev_end    = 1'b0;
   logic                           ray_done    = 1'b0;

   // Directed words under the reset setting of one field per ray:
   // zero run of 0, saturating zero run, run at saturation, empty literal,
   // literal of two data words holding 0xFFFF and the end mark value,
   // field end that also closes the ray, two swallowed end marks, new ray.
   logic [rrld_pkg::WORD_W-1:0] opening_words [12] = '{
      16'h0000, 16'h7FFF, 16'h0005, 16'h8000, 16'h8002, 16'hFFFF,
      16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0003, 16'h0001
   };

   // Directed words with three fields per ray: end mark at ray start,
   // double end mark, swallowed end, zero run landing exactly on capacity,
   // zero run at capacity, data word past capacity, then three fields closing.
   logic [rrld_pkg::WORD_W-1:0] three_field_words [12] = '{
      16'h0001, 16'h0001, 16'h0001, 16'h1000, 16'h0000, 16'h8001,
      16'h8000, 16'h0001, 16'h0002, 16'h0001, 16'h4000, 16'h0001
   };

   // Random phases: extremes of the register, out-of-range values, and one drawn
   logic [rrld_pkg::NFIELDS_W-1:0] field_settings [7] = '{
      6'd2, 6'd32, 6'd0, 6'd63, 6'd33, 6'd1, 6'd5
   };

   function automatic int draw_wait();
      if (rush)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic int effective_fields();
      if (fields_cfg == 0)
         return 1;
      if (fields_cfg > MAX_FIELDS)
         return MAX_FIELDS;
      return int'(fields_cfg);
   endfunction

   // Advance the gate counter, saturating at capacity; report the overflow
   function automatic logic bump_gates(input int unsigned n);
      int unsigned sum;
      logic        ovf;
      sum = int'(gate_cnt) + n;
      ovf = (sum > MAX_GATES);
      gate_cnt = ovf ? MAX_GATES : int'(sum);
      return ovf;
   endfunction

   function automatic rrld_pkg::rsp_item_type make_result(
      input rrld_pkg::kind_type k, input logic [rrld_pkg::WORD_W-1:0] v,
      input logic [rrld_pkg::RUN_W-1:0] run, input logic [rrld_pkg::FIELD_W-1:0] fld,
      input logic [rrld_pkg::GATE_W-1:0] gate, input logic ovf, input logic lst);
      rrld_pkg::rsp_item_type r;
      r.kind          = k;
      r.value         = v;
      r.run_length    = run;
      r.field_index   = fld;
      r.gate_position = gate;
      r.overflow      = ovf;
      r.last          = lst;
      return r;
   endfunction

   task automatic close_ray();
      in_literal = 1'b0;
      run_left   = '0;
      field_cur  = '0;
      gate_cnt   = 0;
      prev_end   = 1'b0;
      ray_done   = 1'b1;
   endtask

   // Predict the results of one accepted word and advance the shadow state
   task automatic decode_word(input logic [rrld_pkg::WORD_W-1:0] w);
      logic [rrld_pkg::RUN_W-1:0] len;
      int                         start;
      logic                       ovf;
      logic                       closes;
      len = w[rrld_pkg::RUN_W-1:0];
      if (in_literal) begin
         start = gate_cnt;
         ovf   = bump_gates(1);
         predicted_results.push_back(make_result(rrld_pkg::KIND_DATA, w, '0,
            field_cur, rrld_pkg::GATE_W'(start), ovf, 1'b1));
         run_left = run_left - 1'b1;
         if (run_left == 0)
            in_literal = 1'b0;
      end else if (w == rrld_pkg::END_MARK) begin
         // end marks after a closed ray are swallowed
         if (!ray_done) begin
            if (prev_end) begin
               predicted_results.push_back(make_result(rrld_pkg::KIND_RAY_END, '0, '0,
                  field_cur - 5'd1, '0, 1'b0, 1'b1));
               close_ray();
            end else begin
               closes = (int'(field_cur) + 1 >= effective_fields());
               predicted_results.push_back(make_result(rrld_pkg::KIND_FIELD_END, '0, '0,
                  field_cur, rrld_pkg::GATE_W'(gate_cnt), 1'b0, !closes));
               if (closes) begin
                  predicted_results.push_back(make_result(rrld_pkg::KIND_RAY_END, '0, '0,
                     field_cur, '0, 1'b0, 1'b1));
                  close_ray();
               end else begin
                  field_cur = field_cur + 5'd1;
                  gate_cnt  = 0;
                  prev_end  = 1'b1;
               end
            end
         end
      end else begin
         ray_done = 1'b0;
         prev_end = 1'b0;
         if (w[rrld_pkg::WORD_W-1]) begin
            // an empty literal run opens nothing
            if (len != 0) begin
               in_literal = 1'b1;
               run_left   = len;
            end
         end else begin
            start = gate_cnt;
            ovf   = bump_gates(32'(len));
            predicted_results.push_back(make_result(rrld_pkg::KIND_ZERO_RUN, '0, len,
               field_cur, rrld_pkg::GATE_W'(start), ovf, 1'b1));
         end
      end
   endtask

   task automatic report_mismatch(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
   endtask

   task automatic queue_word(input logic [rrld_pkg::WORD_W-1:0] w);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Queue one well-formed ray with random content, sometimes led by noise
   // and sometimes closed early by a double end mark or trailed by extra ends
   task automatic queue_random_ray();
      int                          nf;
      int                          segs;
      int                          len;
      bit                          full_ray;
      logic [rrld_pkg::WORD_W-1:0] noise;
      nf = effective_fields();
      full_ray = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            noise = rrld_pkg::WORD_W'($urandom_range(0, 16'hFFFF));
            // keep stray literal headers short
            if (noise[rrld_pkg::WORD_W-1])
               noise[rrld_pkg::RUN_W-1:0] = {9'd0, noise[5:0]};
            queue_word(noise);
         end
      end
      for (int f = 0; f < nf; f++) begin
         segs = $urandom_range(0, full_ray ? 1 : 3);
         for (int s = 0; s < segs; s++) begin
            if ($urandom_range(0, 1)) begin
               len = $urandom_range(0, 12);
               queue_word(16'h8000 | rrld_pkg::WORD_W'(len));
               repeat (len)
                  queue_word(rrld_pkg::WORD_W'($urandom_range(0, 16'hFFFF)));
            end else begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(0, 400);
               if (len == 1)
                  len = 2;
               queue_word(rrld_pkg::WORD_W'(len));
            end
         end
         queue_word(rrld_pkg::END_MARK);
         if (!full_ray && f + 1 < nf && $urandom_range(0, 3) == 0) begin
            queue_word(rrld_pkg::END_MARK);
            break;
         end
      end
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 2))
            queue_word(rrld_pkg::END_MARK);
   endtask

   // Hold until every word is taken and every result has come, then let the
   // pipeline settle so that words without results have left the block too
   task automatic wait_for_idle();
      do
         @(posedge clock);
      while (pending_words.size() != 0 || req_if.valid || predicted_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fields_per_ray(input logic [rrld_pkg::NFIELDS_W-1:0] v);
      @(negedge clock);
      csr_write_data   <= v;
      csr_write_enable <= 1'b1;
      fields_cfg = v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Driver: present the next pending word after its drawn gap, hold the
   // transaction until it is accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_if.valid || req_handshake) begin
            if (gap_left != 0) begin
               req_if.valid <= 1'b0;
               gap_left     <= gap_left - 1;
            end else if (pending_words.size() != 0) begin
               req_if.valid <= 1'b1;
               req_if.word  <= pending_words.pop_front();
               gap_left     <= draw_wait();
               // flip between idling and back-to-back stretches now and then
               if ($urandom_range(0, 39) == 0)
                  rush <= !rush;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result sink: after each accepted result, either keep ready high or drop it
   // for a drawn number of cycles, then raise it again
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_handshake) begin
            if (draw_wait() == 0) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               stall_left   <= $urandom_range(0, MAX_WAIT - 1);
            end
         end else if (!rsp_if.ready) begin
            if (stall_left == 0)
               rsp_if.ready <= 1'b1;
            else
               stall_left <= stall_left - 1;
         end
      end
   end

   // Monitor: check each result transaction against the oldest prediction,
   // then predict from any word accepted at this edge
   always @(posedge clock) begin : monitor
      rrld_pkg::rsp_item_type want;
      if (reset) begin
         req_handshake <= 1'b0;
         rsp_handshake <= 1'b0;
      end else begin
         req_handshake <= req_if.valid && req_if.ready;
         rsp_handshake <= rsp_if.valid && rsp_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_results.size() == 0) begin
               $error("unexpected result: kind %0d value 0x%0h", rsp_if.kind, rsp_if.value);
               error_count++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_if.kind !== want.kind)
                  report_mismatch("kind", 32'(want.kind), 32'(rsp_if.kind));
               if (rsp_if.value !== want.value)
                  report_mismatch("value", 32'(want.value), 32'(rsp_if.value));
               if (rsp_if.run_length !== want.run_length)
                  report_mismatch("run_length", 32'(want.run_length),
                                  32'(rsp_if.run_length));
               if (rsp_if.field_index !== want.field_index)
                  report_mismatch("field_index", 32'(want.field_index),
                                  32'(rsp_if.field_index));
               if (rsp_if.gate_position !== want.gate_position)
                  report_mismatch("gate_position", 32'(want.gate_position),
                                  32'(rsp_if.gate_position));
               if (rsp_if.overflow !== want.overflow)
                  report_mismatch("overflow", 32'(want.overflow), 32'(rsp_if.overflow));
               if (rsp_if.last !== want.last)
                  report_mismatch("last", 32'(want.last), 32'(rsp_if.last));
            end
         end
         if (req_if.valid && req_if.ready)
            decode_word(req_if.word);
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int phase_start;
      req_if.valid     = 1'b0;
      req_if.word      = '0;
      rsp_if.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words, first under the reset register value
      foreach (opening_words[i])
         queue_word(opening_words[i]);
      wait_for_idle();
      write_fields_per_ray(6'd3);
      foreach (three_field_words[i])
         queue_word(three_field_words[i]);
      wait_for_idle();

      // Random rays across register settings; drain fully between settings
      field_settings[6] = rrld_pkg::NFIELDS_W'($urandom_range(0, 63));
      foreach (field_settings[p]) begin
         write_fields_per_ray(field_settings[p]);
         phase_start = words_queued;
         while (words_queued - phase_start < PHASE_WORDS) begin
            queue_random_ray();
            // now and then stop sending until every result is back
            if ($urandom_range(0, 5) == 0)
               wait_for_idle();
            else
               while (pending_words.size() > 4) @(posedge clock);
         end
         wait_for_idle();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[radar_ray_run_length_decoder.f]
design/rrld_pkg.sv
design/rrld_req_if.sv
design/rrld_rsp_if.sv
design/rrld_decoder.sv
design/rrld_out_queue.sv
design/radar_ray_run_length_decoder.sv
tb/radar_ray_run_length_decoder_test.sv
